FILE: rtl/dsv_pkg.sv
// ----------------------------------------------------------------------------
// dsv_pkg
// Shared types and constants for the date string validator.
// ----------------------------------------------------------------------------
package dsv_pkg;

    // Character codes
    localparam logic [7:0] CH_TERM  = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Field limits
    localparam logic [2:0] DM_DIGITS_MAX   = 3'd2;
    localparam logic [2:0] YEAR_DIGITS_MAX = 3'd4;
    localparam logic [2:0] YEAR_DIGITS_SHORT = 3'd2;
    localparam logic [13:0] YEAR_SHORT_MAX = 14'd99;
    localparam logic [13:0] YEAR_BASE      = 14'd2000;
    localparam logic [6:0]  MONTH_MAX      = 7'd12;

    typedef enum logic [1:0] {
        PH_DAY   = 2'd0,
        PH_MONTH = 2'd1,
        PH_YEAR  = 2'd2
    } dsv_phase_t;

    // Request payload: one byte of the string
    typedef struct packed {
        logic [7:0] char_code;
    } dsv_char_t;

    // Request payload: one checked date
    typedef struct packed {
        logic        date_valid;
        logic [6:0]  day_value;
        logic [6:0]  month_value;
        logic [13:0] year_value;
    } dsv_date_t;

    // Parser state handed to the checker at the terminator
    typedef struct packed {
        dsv_phase_t  phase;
        logic [2:0]  count;
        logic [6:0]  day;
        logic [6:0]  month;
        logic [13:0] year;
        logic [6:0]  yr_lo;   // year mod 100
        logic [1:0]  yr_hi;   // (year div 100) mod 4
        logic        error;
    } dsv_parse_t;

endpackage

FILE: rtl/dsv_char_if.sv
// ----------------------------------------------------------------------------
// dsv_char_if
// Valid/ready channel carrying one string byte per request.
// ----------------------------------------------------------------------------
interface dsv_char_if;
    import dsv_pkg::*;

    logic      valid;
    logic      ready;
    dsv_char_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dsv_date_if.sv
// ----------------------------------------------------------------------------
// dsv_date_if
// Valid/ready channel carrying one checked date per request.
// ----------------------------------------------------------------------------
interface dsv_date_if;
    import dsv_pkg::*;

    logic      valid;
    logic      ready;
    dsv_date_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/dsv_check.sv
// ----------------------------------------------------------------------------
// dsv_check
// Final date check: field shape, month range, day against month length.
// ----------------------------------------------------------------------------
module dsv_check
(
    input  dsv_pkg::dsv_parse_t parse,
    output dsv_pkg::dsv_date_t  date
);
    import dsv_pkg::*;

    logic        shape_ok;
    logic        month_ok;
    logic        day_ok;
    logic        leap;
    logic [6:0]  month_len;
    logic [13:0] year_full;
    logic        ok;

    always_comb
    begin
        shape_ok = !parse.error && (parse.phase == PH_YEAR) &&
                   ((parse.count == YEAR_DIGITS_SHORT) || (parse.count == YEAR_DIGITS_MAX));

        // A short year gets the century added; 2000 keeps every residue, so
        // the leap test works on the raw residues.
        year_full = (parse.year <= YEAR_SHORT_MAX) ? (parse.year + YEAR_BASE) : parse.year;

        leap = ((parse.yr_lo[1:0] == 2'd0) && (parse.yr_lo != 7'd0)) ||
               ((parse.yr_lo == 7'd0) && (parse.yr_hi == 2'd0));

        case (parse.month)
            7'd2:                      month_len = leap ? 7'd29 : 7'd28;
            7'd4, 7'd6, 7'd9, 7'd11:   month_len = 7'd30;
            default:                   month_len = 7'd31;
        endcase

        month_ok = (parse.month != 7'd0) && (parse.month <= MONTH_MAX);
        day_ok   = (parse.day != 7'd0) && (parse.day <= month_len);
        ok       = shape_ok && month_ok && day_ok;

        date.date_valid  = ok;
        date.day_value   = ok ? parse.day   : 7'd0;
        date.month_value = ok ? parse.month : 7'd0;
        date.year_value  = ok ? year_full   : 14'd0;
    end

endmodule

FILE: rtl/date_string_validator_core.sv
// ----------------------------------------------------------------------------
// date_string_validator_core
// A terminator byte passes through the input register, then the result register.
// Throughput: one byte per cycle; the output register frees while it waits.
// Only a terminator stalls, and only while the previous result is untaken.
// Reset: rst_n clears the parser to the day field, no error, empty buffers.
// ----------------------------------------------------------------------------
module date_string_validator_core
(
    input  logic        clk,
    input  logic        rst_n,
    dsv_char_if.sink    chars,
    dsv_date_if.source  dates
);
    import dsv_pkg::*;

    // Input register: one byte waiting to be parsed
    logic       in_valid_reg;
    logic [7:0] char_reg;

    // Parser state
    dsv_parse_t parse_reg;
    dsv_parse_t parse_next;

    // Result register
    logic       out_valid_reg;
    dsv_date_t  out_data_reg;
    dsv_date_t  check_date;

    logic       is_term;
    logic       out_free;
    logic       advance;

    // Year digit helpers
    logic [3:0] digit;
    logic [9:0] lo_ext;
    logic [3:0] lo_carry;

    assign is_term  = (char_reg == CH_TERM);
    assign out_free = !out_valid_reg || dates.ready;
    // Parse the held byte unless it is a terminator with nowhere to go
    assign advance  = in_valid_reg && (!is_term || out_free);

    assign chars.ready = !in_valid_reg || advance;
    assign dates.valid = out_valid_reg;
    assign dates.data  = out_data_reg;

    assign digit = 4'(char_reg - CH_ZERO);

    // Keep year mod 400 alongside the year as two residues: low two decimal
    // digits, and the hundreds count mod 4. Shifting in a digit carries
    // (lo*10+d) div 100 into the hundreds.
    always_comb
    begin
        lo_ext   = 10'(parse_reg.yr_lo) * 10'd10 + 10'(digit);
        lo_carry = 4'd0;
        for (int k = 1; k <= 9; k++)
        begin
            if (lo_ext >= 10'(k * 100))
                lo_carry = 4'(k);
        end
    end

    always_comb
    begin
        parse_next = parse_reg;
        if (is_term)
        begin
            // Terminator: result goes out, parser starts over
            parse_next = '0;
            parse_next.phase = PH_DAY;
        end
        else if (parse_reg.error)
        begin
            // Drop everything up to the terminator
            parse_next = parse_reg;
        end
        else if (char_reg == CH_SLASH)
        begin
            if ((parse_reg.count == 3'd0) || (parse_reg.phase == PH_YEAR))
                parse_next.error = 1'b1;
            else
            begin
                parse_next.count = 3'd0;
                case (parse_reg.phase)
                    PH_DAY:   parse_next.phase = PH_MONTH;
                    PH_MONTH: parse_next.phase = PH_YEAR;
                    default:  parse_next.error = 1'b1;
                endcase
            end
        end
        else if (char_reg inside {[CH_ZERO:CH_NINE]})
        begin
            case (parse_reg.phase)
                PH_DAY:
                begin
                    if (parse_reg.count < DM_DIGITS_MAX)
                    begin
                        parse_next.day   = 7'(parse_reg.day * 7'd10 + 7'(digit));
                        parse_next.count = parse_reg.count + 3'd1;
                    end
                    else
                        parse_next.error = 1'b1;
                end
                PH_MONTH:
                begin
                    if (parse_reg.count < DM_DIGITS_MAX)
                    begin
                        parse_next.month = 7'(parse_reg.month * 7'd10 + 7'(digit));
                        parse_next.count = parse_reg.count + 3'd1;
                    end
                    else
                        parse_next.error = 1'b1;
                end
                PH_YEAR:
                begin
                    if (parse_reg.count < YEAR_DIGITS_MAX)
                    begin
                        parse_next.year  = 14'(parse_reg.year * 14'd10 + 14'(digit));
                        parse_next.yr_lo = 7'(lo_ext - 10'(lo_carry) * 10'd100);
                        parse_next.yr_hi = 2'({parse_reg.yr_hi[0], 1'b0} + lo_carry[1:0]);
                        parse_next.count = parse_reg.count + 3'd1;
                    end
                    else
                        parse_next.error = 1'b1;
                end
                default:
                    parse_next.error = 1'b1;
            endcase
        end
        else
        begin
            // Anything else is a bad character
            parse_next.error = 1'b1;
        end
    end

    dsv_check u_check
    (
        .parse (parse_reg),
        .date  (check_date)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (chars.valid && chars.ready)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
            char_reg <= chars.data.char_code;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_reg       <= '0;
            parse_reg.phase <= PH_DAY;
        end
        else if (advance)
            parse_reg <= parse_next;
    end

    // Result register: load on a parsed terminator, clear once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && is_term)
            out_valid_reg <= 1'b1;
        else if (dates.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && is_term)
            out_data_reg <= check_date;
    end

`ifndef ASSERT_OFF
    // A parsed terminator always leaves a result waiting
    a_term_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_term) |=> out_valid_reg)
        else $error("terminator parsed without a result");

    // A reported valid date has a real month and a nonzero day
    a_valid_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.date_valid) |->
        ((out_data_reg.month_value != 7'd0) && (out_data_reg.month_value <= MONTH_MAX) &&
         (out_data_reg.day_value != 7'd0)))
        else $error("valid date out of range");

    // Once in error, non-terminator bytes leave the parser alone
    a_error_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !is_term && parse_reg.error) |=> $stable(parse_reg))
        else $error("parser changed after an error");

    // The digit counter never passes the longest field
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        parse_reg.count <= YEAR_DIGITS_MAX)
        else $error("digit count overflow");
`endif

endmodule
